// File: design/skp_pkg.sv
// ----------------------------------------------------------------------------
// skp_pkg
// Shared types and constants for the skyline rectangle packer.
// ----------------------------------------------------------------------------
`default_nettype none

package skp_pkg;

  // skyline store geometry
  localparam int unsigned MaxPoints = 256;
  localparam int unsigned PtrW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = PtrW + 1;
  localparam int unsigned CoordW    = 13;

  // register indexes
  localparam logic RegBinWidth  = 1'b0;
  localparam logic RegBinHeight = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    StPlaced = 2'd0,
    StNoFit  = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef struct packed {
    logic [CoordW-1:0] req_width;
    logic [CoordW-1:0] req_height;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
  } rsp_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;

  // store access request from the sequencer
  typedef struct packed {
    logic            rd_en;
    logic [PtrW-1:0] rd_addr;
    logic            wr_en;
    logic [PtrW-1:0] wr_addr;
    point_t          wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

// File: design/skp_store.sv
// ----------------------------------------------------------------------------
// skp_store
// Skyline point memory: one write and one registered read per cycle.
// Entry 0 reads as the origin until it is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module skp_store (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire skp_pkg::mem_req_t req_i,
  output skp_pkg::point_t        rd_data_o
);
  import skp_pkg::*;

  point_t mem_q [MaxPoints];
  point_t rd_q;
  logic   ent0_vld_q;
  logic   rd_zero_q;

  // memory array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // origin entry tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent0_vld_q <= 1'b0;
      rd_zero_q  <= 1'b0;
    end else begin
      if (req_i.wr_en && req_i.wr_addr == '0) begin
        ent0_vld_q <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_zero_q <= (req_i.rd_addr == '0) && !ent0_vld_q;
      end
    end
  end

  assign rd_data_o = rd_zero_q ? '0 : rd_q;

endmodule

`default_nettype wire

// File: design/skyline_rect_packer_core.sv
// ----------------------------------------------------------------------------
// skyline_rect_packer_core
// Skyline bottom-left rectangle packer with a memory-held skyline.
// ----------------------------------------------------------------------------
// One request is handled at a time. The sequencer reads the skyline memory
// one point per cycle: each candidate point costs one read plus one read per
// further point its span covers, and a scan ends at the first point that is
// already too far right. A placement then moves the tail of the skyline by
// one memory read and one write per moved point and writes one or two new
// points. A result word may wait at the output while the next request is
// taken. No clearing pass is needed after reset.
`default_nettype none

module skyline_rect_packer_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [skp_pkg::CoordW-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire skp_pkg::req_t             in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output skp_pkg::rsp_t                  out_data_o
);
  import skp_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SOutChk, SIn, SFin, SCpRd, SCpWr, SWrL, SWrR, SResp
  } state_e;

  state_e            state_q;
  logic [CoordW-1:0] bw_q, bh_q;
  logic [CntW-1:0]   cnt_q;
  logic [CoordW-1:0] w_q, h_q;
  logic [CntW-1:0]   i_q, k_q;
  logic [CoordW-1:0] px_q, py_q, last_y_q;
  logic              found_q;
  logic [CoordW-1:0] best_x_q, best_y_q, gap_q, limit_q;
  logic [PtrW-1:0]   left_q;
  logic [CntW-1:0]   right_q;
  logic              ins2_q, desc_q;
  logic [CntW:0]     newcnt_q;
  logic [CntW-1:0]   cp_rd_q, cp_wr_q, cp_left_q;
  rsp_t              res_q, out_q;
  logic              out_vld_q;

  mem_req_t          mreq;
  point_t            rdat;

  skp_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mreq),
    .rd_data_o(rdat)
  );

  // candidate evaluation
  logic              cand_en;
  logic [CoordW-1:0] cand_y, cand_gap, cand_limit;
  logic [CntW-1:0]   cand_right;
  logic              cand_take;
  logic [CntW-1:0]   i_nx, k_nx;
  logic [CoordW:0]   span_end;
  logic [CoordW-1:0] ymax;

  assign i_nx     = i_q + 1'b1;
  assign k_nx     = k_q + 1'b1;
  assign span_end = {1'b0, px_q} + {1'b0, w_q};
  assign ymax     = (rdat.y > py_q) ? rdat.y : py_q;

  always_comb begin
    cand_en    = 1'b0;
    cand_y     = py_q;
    cand_gap   = last_y_q;
    cand_limit = bw_q;
    cand_right = cnt_q;
    if (state_q == SOutChk) begin
      cand_en  = !(({1'b0, w_q} + {1'b0, rdat.x}) > {1'b0, bw_q}) &&
                 !(found_q && rdat.y >= best_y_q) && !(i_nx < cnt_q);
      cand_y   = rdat.y;
      cand_gap = rdat.y;
    end else if (state_q == SIn) begin
      if ({1'b0, rdat.x} >= span_end) begin
        cand_en    = 1'b1;
        cand_limit = rdat.x;
        cand_right = k_q;
      end else if (!(k_nx < cnt_q)) begin
        cand_en  = 1'b1;
        cand_y   = ymax;
        cand_gap = rdat.y;
      end
    end
  end

  assign cand_take = cand_en && !(found_q && cand_y >= best_y_q) &&
                     !(({1'b0, h_q} + {1'b0, cand_y}) > {1'b0, bh_q});

  // placement bookkeeping
  logic [CoordW:0] right_edge;
  logic            ins2;
  logic [CntW-1:0] tail;
  logic [CntW:0]   newcnt;
  logic [CntW-1:0] dst;

  assign right_edge = {1'b0, best_x_q} + {1'b0, w_q};
  assign ins2       = right_edge < {1'b0, limit_q};
  assign tail       = cnt_q - right_q;
  assign dst        = {1'b0, left_q} + (ins2 ? CntW'(2) : CntW'(1));
  assign newcnt     = {1'b0, dst} + {1'b0, tail};

  // memory requests
  always_comb begin
    mreq = '0;
    unique case (state_q)
      SOutChk: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = i_nx[PtrW-1:0];
        if (!(({1'b0, w_q} + {1'b0, rdat.x}) > {1'b0, bw_q}) &&
            !(found_q && rdat.y >= best_y_q)) begin
          mreq.rd_addr = i_nx[PtrW-1:0];
        end
      end
      SIn: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = ((cand_en) ? i_nx[PtrW-1:0] : k_nx[PtrW-1:0]);
      end
      SCpRd: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = cp_rd_q[PtrW-1:0];
      end
      SCpWr: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = cp_wr_q[PtrW-1:0];
        mreq.wr_data = rdat;
      end
      SWrL: begin
        mreq.wr_en     = 1'b1;
        mreq.wr_addr   = left_q;
        mreq.wr_data.x = best_x_q;
        mreq.wr_data.y = best_y_q + h_q;
      end
      SWrR: begin
        mreq.wr_en     = 1'b1;
        mreq.wr_addr   = left_q + 1'b1;
        mreq.wr_data.x = right_edge[CoordW-1:0];
        mreq.wr_data.y = gap_q;
      end
      SIdle: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = '0;
      end
      default: mreq = '0;
    endcase
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      bw_q      <= CoordW'(4096);
      bh_q      <= CoordW'(4096);
      cnt_q     <= CntW'(1);
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegBinWidth) begin
          bw_q <= cfg_data_i;
        end else begin
          bh_q <= cfg_data_i;
        end
      end
      // output word taken while no new one is loaded
      if (out_vld_q && out_ready_i && state_q != SResp) begin
        out_vld_q <= 1'b0;
      end
      if (cand_take) begin
        found_q  <= 1'b1;
        best_y_q <= cand_y;
        best_x_q <= (state_q == SOutChk) ? rdat.x : px_q;
        left_q   <= i_q[PtrW-1:0];
        right_q  <= cand_right;
        gap_q    <= cand_gap;
        limit_q  <= cand_limit;
      end
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            w_q     <= in_data_i.req_width;
            h_q     <= in_data_i.req_height;
            i_q     <= '0;
            found_q <= 1'b0;
            state_q <= SOutChk;
          end
        end
        SOutChk: begin
          if (({1'b0, w_q} + {1'b0, rdat.x}) > {1'b0, bw_q}) begin
            state_q <= SFin;
          end else if (found_q && rdat.y >= best_y_q) begin
            i_q     <= i_nx;
            state_q <= (i_nx < cnt_q) ? SOutChk : SFin;
          end else begin
            px_q     <= rdat.x;
            py_q     <= rdat.y;
            last_y_q <= rdat.y;
            k_q      <= i_nx;
            if (i_nx < cnt_q) begin
              state_q <= SIn;
            end else begin
              state_q <= SFin;
            end
          end
        end
        SIn: begin
          if (cand_en) begin
            i_q     <= i_nx;
            state_q <= (i_nx < cnt_q) ? SOutChk : SFin;
          end else begin
            py_q     <= ymax;
            last_y_q <= rdat.y;
            k_q      <= k_nx;
          end
        end
        SFin: begin
          ins2_q   <= ins2;
          newcnt_q <= newcnt;
          desc_q   <= dst > right_q;
          cp_left_q <= tail;
          if (dst > right_q) begin
            cp_rd_q <= cnt_q - 1'b1;
            cp_wr_q <= newcnt[CntW-1:0] - 1'b1;
          end else begin
            cp_rd_q <= right_q;
            cp_wr_q <= dst;
          end
          if (!found_q) begin
            res_q   <= '{status: StNoFit, pos_x: '0, pos_y: '0};
            state_q <= SResp;
          end else if (newcnt > (CntW+1)'(MaxPoints)) begin
            res_q   <= '{status: StFull, pos_x: '0, pos_y: '0};
            state_q <= SResp;
          end else begin
            res_q   <= '{status: StPlaced, pos_x: best_x_q, pos_y: best_y_q};
            state_q <= (tail != '0 && dst != right_q) ? SCpRd : SWrL;
          end
        end
        SCpRd: begin
          state_q <= SCpWr;
        end
        SCpWr: begin
          cp_left_q <= cp_left_q - 1'b1;
          if (desc_q) begin
            cp_rd_q <= cp_rd_q - 1'b1;
            cp_wr_q <= cp_wr_q - 1'b1;
          end else begin
            cp_rd_q <= cp_rd_q + 1'b1;
            cp_wr_q <= cp_wr_q + 1'b1;
          end
          state_q <= (cp_left_q == CntW'(1)) ? SWrL : SCpRd;
        end
        SWrL: begin
          cnt_q   <= newcnt_q[CntW-1:0];
          state_q <= ins2_q ? SWrR : SResp;
        end
        SWrR: begin
          state_q <= SResp;
        end
        SResp: begin
          if (!out_vld_q || out_ready_i) begin
            out_q     <= res_q;
            out_vld_q <= 1'b1;
            state_q   <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
